FILE: hdl/ect_pkg.sv
package ect_pkg;

  localparam int unsigned ACTION_W  = 4;
  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned SETTING_W = 14;
  localparam int unsigned COUNT_W   = 20;
  // setting * 100 needs one bit more than the count
  localparam int unsigned TARGET_W  = 21;
  localparam int unsigned SUM_W     = VALUE_W + 2;
  localparam int unsigned RESULT_W  = 2 + 1 + 1 + SETTING_W + 2 * COUNT_W;
  localparam int unsigned M_DATA_W  = ((RESULT_W + 7) / 8) * 8;

  localparam logic [SETTING_W-1:0] MAX_TENTHS   = 14'd9990;
  localparam logic [SETTING_W-1:0] RESET_TENTHS = 14'd100;
  localparam logic [6:0]           MS_PER_TENTH = 7'd100;
  localparam logic [COUNT_W-1:0]   COUNT_MAX    = {COUNT_W{1'b1}};
  localparam logic [TARGET_W-1:0]  RESET_TARGET = 21'd10000;

  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_PAUSED  = 2'd2,
    MODE_FOCUS   = 2'd3
  } mode_e;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK         = 4'd0,
    ACT_START        = 4'd1,
    ACT_STOP         = 4'd2,
    ACT_TOGGLE       = 4'd3,
    ACT_PAUSE        = 4'd4,
    ACT_RESUME       = 4'd5,
    ACT_RESET        = 4'd6,
    ACT_FOCUS        = 4'd7,
    ACT_FOCUS_OFF    = 4'd8,
    ACT_FOCUS_TOGGLE = 4'd9,
    ACT_LOAD_TIME    = 4'd10,
    ACT_ADD_TIME     = 4'd11
  } action_e;

  typedef struct packed {
    mode_e                mode;
    logic [SETTING_W-1:0] setting;
    logic [COUNT_W-1:0]   elapsed;
    logic [TARGET_W-1:0]  target;
  } ect_state_t;

  // first member lands in the top bits: mode ends up at bit 0
  typedef struct packed {
    logic [COUNT_W-1:0]   elapsed_out_ms;
    logic [COUNT_W-1:0]   time_left_ms;
    logic [SETTING_W-1:0] setting_tenths;
    logic                 expired;
    logic                 lamp_on;
    mode_e                mode;
  } ect_result_t;

endpackage

FILE: hdl/exposure_countdown_timer.sv
// An accepted input beat goes through the input register, then the state
// update into the result register, before its result beat appears.
// Throughput: one beat per cycle; the input side keeps taking beats while a
// result waits, and stalls only when both stages are full.
// Reset: mode stopped, setting 10.0 s, elapsed count cleared, both stages empty.
module exposure_countdown_timer import ect_pkg::*; #(
  parameter logic [SETTING_W-1:0] SETTING_MAX = MAX_TENTHS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [15:0]         s_axis_tdata_i,   // [15:0] value_tenths
  input  logic [3:0]          s_axis_tuser_i,   // [3:0] action
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [1:0] mode, [2] lamp_on, [3] expired, [17:4] setting_tenths,
  // [37:18] time_left_ms, [57:38] elapsed_out_ms, [63:58] zero
  output logic [M_DATA_W-1:0] m_axis_tdata_o
);

  logic                        in_valid_q;
  logic [ACTION_W-1:0]         action_q;
  logic signed [VALUE_W-1:0]   value_q;
  logic                        out_valid_q;
  ect_result_t                 result_q;
  ect_result_t                 result_d;
  ect_state_t                  state_q;
  ect_state_t                  state_d;
  logic                        advance;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      action_q <= s_axis_tuser_i;
      value_q  <= $signed(s_axis_tdata_i);
    end
  end

  ect_core #(
    .SETTING_MAX (SETTING_MAX)
  ) u_core (
    .state_i        (state_q),
    .action_i       (action_q),
    .value_tenths_i (value_q),
    .state_o        (state_d),
    .result_o       (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode    <= MODE_STOPPED;
      state_q.setting <= RESET_TENTHS;
      state_q.elapsed <= '0;
      state_q.target  <= RESET_TARGET;
      out_valid_q     <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) result_q <= result_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(M_DATA_W-RESULT_W){1'b0}}, result_q};

  // the count only lives in running and paused
  a_idle_count_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.mode == MODE_STOPPED || state_q.mode == MODE_FOCUS) |-> state_q.elapsed == '0)
    else $error("elapsed count not cleared outside running/paused");

  a_target_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.target == TARGET_W'(state_q.setting) * TARGET_W'(MS_PER_TENTH))
    else $error("target out of step with setting");

  a_setting_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.setting <= SETTING_MAX)
    else $error("setting above maximum");

  a_expire_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && result_q.expired) |->
      (result_q.mode == MODE_STOPPED && result_q.elapsed_out_ms == '0))
    else $error("expired beat not reporting stopped");

  a_stall_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |=> $stable(state_q))
    else $error("state changed while result stalled");

endmodule

FILE: hdl/ect_core.sv
module ect_core import ect_pkg::*; #(
  parameter logic [SETTING_W-1:0] SETTING_MAX = MAX_TENTHS
) (
  input  ect_state_t                state_i,
  input  logic [ACTION_W-1:0]       action_i,
  input  logic signed [VALUE_W-1:0] value_tenths_i,
  output ect_state_t                state_o,
  output ect_result_t               result_o
);

  action_e              action;
  logic signed [SUM_W-1:0] value_ext;
  logic signed [SUM_W-1:0] sum_s;
  logic [SETTING_W-1:0] clamped;
  logic [COUNT_W-1:0]   elapsed_inc;
  mode_e                mode_n;
  logic [SETTING_W-1:0] setting_n;
  logic [COUNT_W-1:0]   elapsed_n;
  logic [TARGET_W-1:0]  target_n;
  logic                 expired;
  logic                 active;
  logic [TARGET_W-1:0]  rem_full;

  assign action    = action_e'(action_i);
  assign value_ext = {{(SUM_W-VALUE_W){value_tenths_i[VALUE_W-1]}}, value_tenths_i};

  // load takes the value alone, add puts it on top of the setting
  always_comb begin
    if (action == ACT_ADD_TIME) begin
      sum_s = $signed({{(SUM_W-SETTING_W){1'b0}}, state_i.setting}) + value_ext;
    end else begin
      sum_s = value_ext;
    end
    if (sum_s < 0) begin
      clamped = '0;
    end else if (sum_s > $signed({{(SUM_W-SETTING_W){1'b0}}, SETTING_MAX})) begin
      clamped = SETTING_MAX;
    end else begin
      clamped = sum_s[SETTING_W-1:0];
    end
  end

  assign elapsed_inc = (state_i.elapsed == COUNT_MAX) ? state_i.elapsed
                                                      : state_i.elapsed + 1'b1;

  always_comb begin
    mode_n    = state_i.mode;
    setting_n = state_i.setting;
    elapsed_n = state_i.elapsed;
    expired   = 1'b0;
    unique case (action)
      ACT_TICK: begin
        if (state_i.mode == MODE_RUNNING) begin
          if ({1'b0, elapsed_inc} >= state_i.target) begin
            mode_n    = MODE_STOPPED;
            elapsed_n = '0;
            expired   = 1'b1;
          end else begin
            elapsed_n = elapsed_inc;
          end
        end
      end
      ACT_START: begin
        if (state_i.mode != MODE_RUNNING) begin
          mode_n    = MODE_RUNNING;
          elapsed_n = '0;
        end
      end
      ACT_STOP, ACT_RESET: begin
        mode_n    = MODE_STOPPED;
        elapsed_n = '0;
      end
      ACT_TOGGLE: begin
        if (state_i.mode == MODE_RUNNING) begin
          mode_n = MODE_PAUSED;
        end else if (state_i.mode == MODE_PAUSED) begin
          mode_n = MODE_RUNNING;
        end else begin
          mode_n    = MODE_RUNNING;
          elapsed_n = '0;
        end
      end
      ACT_PAUSE: begin
        if (state_i.mode == MODE_RUNNING) mode_n = MODE_PAUSED;
      end
      ACT_RESUME: begin
        if (state_i.mode == MODE_PAUSED) mode_n = MODE_RUNNING;
      end
      ACT_FOCUS: begin
        if (state_i.mode == MODE_STOPPED || state_i.mode == MODE_PAUSED) begin
          mode_n    = MODE_FOCUS;
          elapsed_n = '0;
        end
      end
      ACT_FOCUS_OFF: begin
        if (state_i.mode == MODE_FOCUS) mode_n = MODE_STOPPED;
      end
      ACT_FOCUS_TOGGLE: begin
        if (state_i.mode == MODE_FOCUS) begin
          mode_n = MODE_STOPPED;
        end else if (state_i.mode != MODE_RUNNING) begin
          mode_n    = MODE_FOCUS;
          elapsed_n = '0;
        end
      end
      ACT_LOAD_TIME, ACT_ADD_TIME: begin
        setting_n = clamped;
      end
      default: begin
      end
    endcase
  end

  assign target_n = TARGET_W'(setting_n) * TARGET_W'(MS_PER_TENTH);
  assign active   = (mode_n == MODE_RUNNING) || (mode_n == MODE_PAUSED);

  always_comb begin
    if (!active) begin
      rem_full = target_n;
    end else if ({1'b0, elapsed_n} >= target_n) begin
      rem_full = '0;
    end else begin
      rem_full = target_n - {1'b0, elapsed_n};
    end
  end

  assign state_o.mode    = mode_n;
  assign state_o.setting = setting_n;
  assign state_o.elapsed = elapsed_n;
  assign state_o.target  = target_n;

  assign result_o.mode           = mode_n;
  assign result_o.lamp_on        = (mode_n == MODE_RUNNING) || (mode_n == MODE_FOCUS);
  assign result_o.expired        = expired;
  assign result_o.setting_tenths = setting_n;
  assign result_o.time_left_ms   = (rem_full > {1'b0, COUNT_MAX}) ? COUNT_MAX
                                                                  : rem_full[COUNT_W-1:0];
  assign result_o.elapsed_out_ms = active ? elapsed_n : '0;

endmodule
